### hw/rtl/md5_pkg.sv
// md5_pkg: shared types, constants and round tables for the MD5 digest core.
// Used by md5_ctrl, md5_datapath and md5_digest_core. No dependencies.
package md5_pkg;

    localparam logic [31:0] IV_A = 32'h67452301;
    localparam logic [31:0] IV_B = 32'hefcdab89;
    localparam logic [31:0] IV_C = 32'h98badcfe;
    localparam logic [31:0] IV_D = 32'h10325476;
    localparam logic [7:0]  PAD_MARK = 8'h80;

    // Word indexes that matter to the padding sequence, then the last round and byte position
    localparam logic [3:0] LAST_DATA_WORD = 4'd13;
    localparam logic [3:0] LAST_WORD      = 4'd15;
    localparam logic [5:0] LAST_ROUND     = 6'd63;
    localparam logic [5:0] LAST_POS       = 6'd63;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_FOLD,
        ST_PAD_HEAD,
        ST_ZERO,
        ST_LEN,
        ST_EMIT
    } md5_state_t;

    typedef struct packed {
        logic take_byte;
        logic init_rounds;
        logic do_round;
        logic fold;
        logic pad_head;
        logic zero_word;
        logic write_len;
        logic emit;
    } md5_cmd_t;

    typedef struct packed {
        logic       pos_end;
        logic [3:0] pad_word;
        logic [3:0] fill_ptr;
        logic       round_end;
        logic       out_free;
    } md5_status_t;

    function automatic logic [31:0] sine_k(input logic [5:0] i);
        logic [31:0] k;
        begin
            unique case (i)
                6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
                6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
                6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
                6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
                6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
                6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
                6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
                6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
                6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
                6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
                6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
                6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
                6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
                6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
                6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
                6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
                6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
                6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
                6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
                6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
                6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
                6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
                6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
                6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
                6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
                6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
                6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
                6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
                6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
                6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
                6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
                6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
                default: k = 32'h0;
            endcase
            return k;
        end
    endfunction

    // index is {round group, round mod 4}
    function automatic logic [4:0] rot_amount(input logic [3:0] idx);
        logic [4:0] s;
        begin
            unique case (idx)
                4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
                4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
                4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
                4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  4'd15: s = 5'd21;
                default: s = 5'd0;
            endcase
            return s;
        end
    endfunction

    function automatic logic [31:0] bswap32(input logic [31:0] v);
        return {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

endpackage

### hw/rtl/md5_ctrl.sv
// md5_ctrl: sequencer for byte intake, padding, the 64-round loop and digest hand-off.
// Depends on md5_pkg; drives md5_datapath through md5_cmd_t.
module md5_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_has_byte,
    input  logic                 in_last,
    output logic                 in_ready,
    input  md5_pkg::md5_status_t status,
    output md5_pkg::md5_cmd_t    cmd
);
    import md5_pkg::*;

    md5_state_t state_reg, state_next;
    md5_state_t after_reg, after_next;   // where to go once a block is folded in

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            after_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
            after_reg <= after_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        after_next = after_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.take_byte = in_has_byte;
                    if (in_has_byte && status.pos_end)
                    begin
                        cmd.init_rounds = 1'b1;
                        after_next      = in_last ? ST_PAD_HEAD : ST_IDLE;
                        state_next      = ST_ROUND;
                    end
                    else if (in_last)
                    begin
                        state_next = ST_PAD_HEAD;
                    end
                end
            end
            ST_ROUND:
            begin
                cmd.do_round = 1'b1;
                if (status.round_end)
                begin
                    state_next = ST_FOLD;
                end
            end
            ST_FOLD:
            begin
                cmd.fold   = 1'b1;
                state_next = after_reg;
            end
            ST_PAD_HEAD:
            begin
                cmd.pad_head = 1'b1;
                if (status.pad_word == LAST_WORD)
                begin
                    // mark filled the block: run it, then a block of zeros and length
                    cmd.init_rounds = 1'b1;
                    after_next      = ST_ZERO;
                    state_next      = ST_ROUND;
                end
                else if (status.pad_word == LAST_DATA_WORD)
                begin
                    state_next = ST_LEN;
                end
                else
                begin
                    state_next = ST_ZERO;
                end
            end
            ST_ZERO:
            begin
                cmd.zero_word = 1'b1;
                if (status.fill_ptr == LAST_WORD)
                begin
                    cmd.init_rounds = 1'b1;
                    after_next      = ST_ZERO;
                    state_next      = ST_ROUND;
                end
                else if (status.fill_ptr == LAST_DATA_WORD)
                begin
                    state_next = ST_LEN;
                end
            end
            ST_LEN:
            begin
                cmd.write_len   = 1'b1;
                cmd.init_rounds = 1'b1;
                after_next      = ST_EMIT;
                state_next      = ST_ROUND;
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### hw/rtl/md5_datapath.sv
// md5_datapath: block buffer, byte counter, chaining and round words, round logic
// and the digest output register. Depends on md5_pkg; controlled by md5_ctrl.
module md5_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  md5_pkg::md5_cmd_t    cmd,
    output md5_pkg::md5_status_t status,
    input  logic [7:0]           data_byte,
    input  logic                 out_ready,
    output logic                 out_valid,
    output logic [63:0]          digest_head,
    output logic [63:0]          digest_tail
);
    import md5_pkg::*;

    logic [31:0]  block_reg [16];
    logic [63:0]  byte_count_reg;
    logic [31:0]  chain_reg [4];
    logic [31:0]  round_reg [4];
    logic [5:0]   round_index_reg;
    logic [3:0]   fill_ptr_reg;
    logic         out_valid_reg;
    logic [127:0] out_data_reg;

    logic [5:0]  pos;
    logic [3:0]  pos_word;
    logic [1:0]  pos_lane;
    logic [31:0] mark_word;
    logic [63:0] bit_len;

    logic [31:0] a, b, c, d;
    logic [31:0] f;
    logic [3:0]  g;
    logic [3:0]  i_low;
    logic [31:0] sum;
    logic [63:0] rot_wide;
    logic [31:0] b_new;

    assign pos      = byte_count_reg[5:0];
    assign pos_word = pos[5:2];
    assign pos_lane = pos[1:0];
    assign bit_len  = {byte_count_reg[60:0], 3'b000};

    // padding word: bytes already in place, then the mark, zeros above
    always_comb
    begin
        case (pos_lane)
            2'd0:    mark_word = {24'h0, PAD_MARK};
            2'd1:    mark_word = {16'h0, PAD_MARK, block_reg[pos_word][7:0]};
            2'd2:    mark_word = {8'h0, PAD_MARK, block_reg[pos_word][15:0]};
            default: mark_word = {PAD_MARK, block_reg[pos_word][23:0]};
        endcase
    end

    // one MD5 round
    assign a     = round_reg[0];
    assign b     = round_reg[1];
    assign c     = round_reg[2];
    assign d     = round_reg[3];
    assign i_low = round_index_reg[3:0];

    always_comb
    begin
        case (round_index_reg[5:4])
            2'd0:
            begin
                f = (b & c) | (~b & d);
                g = i_low;
            end
            2'd1:
            begin
                f = (d & b) | (~d & c);
                g = 4'(i_low * 4'd5 + 4'd1);
            end
            2'd2:
            begin
                f = b ^ c ^ d;
                g = 4'(i_low * 4'd3 + 4'd5);
            end
            default:
            begin
                f = c ^ (b | ~d);
                g = 4'(i_low * 4'd7);
            end
        endcase
    end

    assign sum      = f + a + sine_k(round_index_reg) + block_reg[g];
    assign rot_wide = {sum, sum} << rot_amount({round_index_reg[5:4], round_index_reg[1:0]});
    assign b_new    = b + rot_wide[63:32];

    // block buffer: no reset, every word is written before the rounds read it
    always_ff @(posedge clk)
    begin
        if (cmd.take_byte)
        begin
            if (pos_lane == 2'd0)
            begin
                block_reg[pos_word] <= {24'h0, data_byte};
            end
            else
            begin
                block_reg[pos_word][{pos_lane, 3'b000} +: 8] <= data_byte;
            end
        end
        if (cmd.pad_head)
        begin
            block_reg[pos_word] <= mark_word;
        end
        if (cmd.zero_word)
        begin
            block_reg[fill_ptr_reg] <= '0;
        end
        if (cmd.write_len)
        begin
            block_reg[14] <= bit_len[31:0];
            block_reg[15] <= bit_len[63:32];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg  <= '0;
            chain_reg[0]    <= IV_A;
            chain_reg[1]    <= IV_B;
            chain_reg[2]    <= IV_C;
            chain_reg[3]    <= IV_D;
            round_reg[0]    <= '0;
            round_reg[1]    <= '0;
            round_reg[2]    <= '0;
            round_reg[3]    <= '0;
            round_index_reg <= '0;
            fill_ptr_reg    <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.take_byte)
            begin
                byte_count_reg <= byte_count_reg + 64'd1;
            end
            if (cmd.init_rounds)
            begin
                round_reg[0]    <= chain_reg[0];
                round_reg[1]    <= chain_reg[1];
                round_reg[2]    <= chain_reg[2];
                round_reg[3]    <= chain_reg[3];
                round_index_reg <= '0;
            end
            if (cmd.do_round)
            begin
                round_reg[0]    <= d;
                round_reg[1]    <= b_new;
                round_reg[2]    <= b;
                round_reg[3]    <= c;
                round_index_reg <= round_index_reg + 6'd1;
            end
            if (cmd.fold)
            begin
                chain_reg[0] <= chain_reg[0] + round_reg[0];
                chain_reg[1] <= chain_reg[1] + round_reg[1];
                chain_reg[2] <= chain_reg[2] + round_reg[2];
                chain_reg[3] <= chain_reg[3] + round_reg[3];
            end
            // word 15 wraps the pointer to 0, ready for the extra padding block
            if (cmd.pad_head)
            begin
                fill_ptr_reg <= pos_word + 4'd1;
            end
            if (cmd.zero_word)
            begin
                fill_ptr_reg <= fill_ptr_reg + 4'd1;
            end
            if (cmd.emit)
            begin
                out_valid_reg  <= 1'b1;
                chain_reg[0]   <= IV_A;
                chain_reg[1]   <= IV_B;
                chain_reg[2]   <= IV_C;
                chain_reg[3]   <= IV_D;
                byte_count_reg <= '0;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_data_reg <= {bswap32(chain_reg[2]), bswap32(chain_reg[3]),
                             bswap32(chain_reg[0]), bswap32(chain_reg[1])};
        end
    end

    assign status.pos_end   = (pos == LAST_POS);
    assign status.pad_word  = pos_word;
    assign status.fill_ptr  = fill_ptr_reg;
    assign status.round_end = (round_index_reg == LAST_ROUND);
    assign status.out_free  = !out_valid_reg || out_ready;

    assign out_valid   = out_valid_reg;
    assign digest_head = out_data_reg[63:0];
    assign digest_tail = out_data_reg[127:64];

endmodule

### hw/rtl/md5_digest_core.sv
// md5_digest_core: top level of the MD5 digest engine, stream in and stream out.
// Depends on md5_pkg, md5_ctrl and md5_datapath.
//
// Takes one message byte per input word (tuser marks a word that carries a byte,
// tlast ends the message) and returns one 128-bit digest word per message.
// The 64th byte of a block starts the single shared round unit, which holds tready low
// through the 64 rounds and the chaining add, so no byte is taken while a block is
// hashed. After tlast the padding is written one word per cycle, paused while a filled
// padding block runs through the round unit; both length words are written together,
// the last block is hashed, and the digest enters the output register once that
// register is free; tready returns as soon as the digest is in that register, even if
// it has not been taken yet.
module md5_digest_core (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // [7:0] data_byte
    input  logic         s_axis_tuser,   // [0] has_byte
    input  logic         s_axis_tlast,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [127:0] m_axis_tdata    // [63:0] digest_head, [127:64] digest_tail
);
    import md5_pkg::*;

    md5_cmd_t    cmd;
    md5_status_t status;
    logic [63:0] digest_head;
    logic [63:0] digest_tail;

    md5_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_has_byte (s_axis_tuser),
        .in_last     (s_axis_tlast),
        .in_ready    (s_axis_tready),
        .status      (status),
        .cmd         (cmd)
    );

    md5_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .data_byte   (s_axis_tdata),
        .out_ready   (m_axis_tready),
        .out_valid   (m_axis_tvalid),
        .digest_head (digest_head),
        .digest_tail (digest_tail)
    );

    assign m_axis_tdata = {digest_tail, digest_head};

endmodule

### hw/rtl/md5_digest_checker.sv
// md5_digest_checker: port-level assertions for md5_digest_core, attached by bind.
// Depends only on the top level's ports.
module md5_digest_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         s_axis_tlast,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [127:0] m_axis_tdata
);

    // a held digest word stays put
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("digest word changed or dropped while stalled");

    // the end of a message always starts padding work
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
        else $error("input still open right after the last word");

    // the core only goes busy because of an accepted word
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(s_axis_tready) |-> $past(s_axis_tvalid && s_axis_tready))
        else $error("input went busy without an accepted word");

    // a new digest appears only out of a busy period
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("digest appeared while input was idle");

endmodule

bind md5_digest_core md5_digest_checker u_md5_digest_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

### test/tb.sv
// tb: self-checking bench for md5_digest_core, byte stream in and one digest word out.
// Depends on md5_pkg (initial chaining values, pad marker) and the md5_digest_core RTL.
// Directed words from a table first, then random messages against a local MD5 model.
`timescale 1ns / 100ps

module tb;

    localparam int LIMIT_CYCLES = 400000;
    localparam int ITEM_TARGET  = 750;

    typedef struct packed {
        logic [63:0] head;
        logic [63:0] tail;
    } digest_t;

    typedef struct packed {
        logic [7:0]  data;
        logic        has;
        logic        last;
        logic        known;
        logic [63:0] head;
        logic [63:0] tail;
    } stim_row_t;

    typedef enum int {RX_OPEN, RX_CHOPPY, RX_SLOW} rx_mode_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [7:0]   s_axis_tdata;   // [7:0] data_byte
    logic         s_axis_tuser;   // [0] has_byte
    logic         s_axis_tlast;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [127:0] m_axis_tdata;   // [63:0] digest_head, [127:64] digest_tail

    md5_digest_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    logic [31:0] round_k [0:63] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    int rot_s [0:15] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};

    // Directed words: empty message, "a" closed by an empty last word, "abc" closed
    // by a byte with last, idle words, and the 0x00 / 0xff extremes.
    stim_row_t dir_rows [0:14] = '{
        '{8'h00, 1'b0, 1'b1, 1'b1, 64'hd41d8cd98f00b204, 64'he9800998ecf8427e},
        '{8'h61, 1'b1, 1'b0, 1'b0, 64'h0, 64'h0},
        '{8'hff, 1'b0, 1'b0, 1'b0, 64'h0, 64'h0},
        '{8'h00, 1'b0, 1'b1, 1'b1, 64'h0cc175b9c0f1b6a8, 64'h31c399e269772661},
        '{8'h61, 1'b1, 1'b0, 1'b0, 64'h0, 64'h0},
        '{8'h62, 1'b1, 1'b0, 1'b0, 64'h0, 64'h0},
        '{8'h63, 1'b1, 1'b1, 1'b1, 64'h900150983cd24fb0, 64'hd6963f7d28e17f72},
        '{8'h61, 1'b1, 1'b1, 1'b1, 64'h0cc175b9c0f1b6a8, 64'h31c399e269772661},
        '{8'hff, 1'b1, 1'b0, 1'b0, 64'h0, 64'h0},
        '{8'h00, 1'b1, 1'b0, 1'b0, 64'h0, 64'h0},
        '{8'h00, 1'b0, 1'b0, 1'b0, 64'h0, 64'h0},
        '{8'hff, 1'b1, 1'b1, 1'b0, 64'h0, 64'h0},
        '{8'h00, 1'b1, 1'b1, 1'b0, 64'h0, 64'h0},
        '{8'hff, 1'b0, 1'b0, 1'b0, 64'h0, 64'h0},
        '{8'hff, 1'b0, 1'b1, 1'b0, 64'h0, 64'h0}
    };

    // local MD5 state
    logic [31:0] chain_w [0:3];
    logic [31:0] blk_w [0:15];
    logic [63:0] msg_bytes;

    digest_t  pending_digests [$];
    digest_t  front_dg;
    int       errors;
    int       items_sent;
    int       bytes_sent;
    int       digests_sent;
    int       digests_seen;
    int       msgs_sent;
    int       burst_left;
    int       cycle_count;
    rx_mode_t rx_mode;
    int       rx_left;

    function automatic logic [31:0] byte_rev32(input logic [31:0] v);
        return {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

    function automatic void md5_chain_reset();
        chain_w[0] = md5_pkg::IV_A;
        chain_w[1] = md5_pkg::IV_B;
        chain_w[2] = md5_pkg::IV_C;
        chain_w[3] = md5_pkg::IV_D;
        msg_bytes  = 64'd0;
    endfunction

    function automatic void md5_compress();
        logic [31:0] a, b, c, d, f;
        int g, s;
        a = chain_w[0];
        b = chain_w[1];
        c = chain_w[2];
        d = chain_w[3];
        for (int i = 0; i < 64; i++)
        begin
            case (i / 16)
                0:
                begin
                    f = (b & c) | (~b & d);
                    g = i;
                end
                1:
                begin
                    f = (d & b) | (~d & c);
                    g = (5 * i + 1) % 16;
                end
                2:
                begin
                    f = b ^ c ^ d;
                    g = (3 * i + 5) % 16;
                end
                default:
                begin
                    f = c ^ (b | ~d);
                    g = (7 * i) % 16;
                end
            endcase
            f = f + a + round_k[i] + blk_w[g];
            s = rot_s[(i / 16) * 4 + i % 4];
            a = d;
            d = c;
            c = b;
            b = b + ((f << s) | (f >> (32 - s)));
        end
        chain_w[0] += a;
        chain_w[1] += b;
        chain_w[2] += c;
        chain_w[3] += d;
    endfunction

    // first byte of a word clears the rest of it
    function automatic void place_byte(input int pos, input logic [7:0] v);
        if ((pos & 3) == 0)
            blk_w[pos >> 2] = 32'd0;
        blk_w[pos >> 2][(pos & 3) * 8 +: 8] = v;
    endfunction

    // Advances the local MD5 by one word; returns 1 with the digest on a last word.
    function automatic bit md5_step(input logic [7:0] data, input logic has,
                                    input logic last, output digest_t dg);
        int pos;
        logic [63:0] bits;
        dg = '0;
        if (has)
        begin
            pos = int'(msg_bytes[5:0]);
            place_byte(pos, data);
            msg_bytes++;
            if (pos == 63)
                md5_compress();
        end
        if (!last)
            return 1'b0;
        pos = int'(msg_bytes[5:0]);
        place_byte(pos, md5_pkg::PAD_MARK);
        pos++;
        // no room for the length field: pad out this block and start another
        if (pos > 56)
        begin
            while (pos < 64)
            begin
                place_byte(pos, 8'h00);
                pos++;
            end
            md5_compress();
            pos = 0;
        end
        while (pos < 56)
        begin
            place_byte(pos, 8'h00);
            pos++;
        end
        bits      = msg_bytes << 3;
        blk_w[14] = bits[31:0];
        blk_w[15] = bits[63:32];
        md5_compress();
        dg.head = {byte_rev32(chain_w[0]), byte_rev32(chain_w[1])};
        dg.tail = {byte_rev32(chain_w[2]), byte_rev32(chain_w[3])};
        md5_chain_reset();
        return 1'b1;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // One word through the input handshake, then a gap once the current burst is used up.
    task automatic send_word(input logic [7:0] d, input logic has, input logic last,
                             input logic known, input digest_t known_dg);
        digest_t dg;
        s_axis_tdata  <= d;
        s_axis_tuser  <= has;
        s_axis_tlast  <= last;
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        if (md5_step(d, has, last, dg))
        begin
            pending_digests.insert(pending_digests.size(), known ? known_dg : dg);
            digests_sent++;
        end
        if (has || last)
            items_sent++;
        if (has)
            bytes_sent++;
        if (last)
            msgs_sent++;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                    : $urandom_range(0, 12);
        end
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending_digests.size() != 0);
    endtask

    task automatic send_message(input int len, input bit last_has_byte);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 15) == 0)
                send_word(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0, '0);
            send_word(8'($urandom_range(0, 255)), 1'b1,
                      (i == len - 1) && last_has_byte, 1'b0, '0);
        end
        if (!last_has_byte)
            send_word(8'($urandom_range(0, 255)), 1'b0, 1'b1, 1'b0, '0);
    endtask

    function automatic int pick_length();
        int r;
        int edges [0:9] = '{55, 56, 57, 63, 64, 65, 119, 120, 127, 128};
        r = $urandom_range(0, 99);
        if (r < 55)
            return $urandom_range(0, 12);
        if (r < 80)
            return $urandom_range(13, 50);
        if (r < 93)
            return edges[$urandom_range(0, 9)];
        return $urandom_range(66, 200);
    endfunction

    initial
    begin
        int len;
        bit with_byte;
        errors        = 0;
        items_sent    = 0;
        bytes_sent    = 0;
        digests_sent  = 0;
        msgs_sent     = 0;
        burst_left    = 0;
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 8'h00;
        s_axis_tuser  <= 1'b0;
        s_axis_tlast  <= 1'b0;
        md5_chain_reset();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            send_word(dir_rows[i].data, dir_rows[i].has, dir_rows[i].last,
                      dir_rows[i].known, {dir_rows[i].head, dir_rows[i].tail});
        drain_results();

        while (items_sent < ITEM_TARGET)
        begin
            len = pick_length();
            with_byte = (len > 0) && ($urandom_range(0, 1) == 1);
            send_message(len, with_byte);
            if (msgs_sent == 30)
                drain_results();
        end

        drain_results();
        repeat (200) @(posedge clk);
        $display("Covered %0d messages, %0d bytes, %0d words with data or end mark",
                 msgs_sent, bytes_sent, items_sent);
        $display("Digests checked: %0d of %0d, mismatches: %0d",
                 digests_seen, digests_sent, errors);
        if (errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // receiver backpressure: open, choppy and slow stretches of random length
    always @(posedge clk)
    begin
        if (rx_left == 0)
        begin
            rx_mode = rx_mode_t'($urandom_range(0, 2));
            rx_left = $urandom_range(1, 60);
        end
        else
            rx_left--;
        case (rx_mode)
            RX_OPEN:   m_axis_tready <= 1'b1;
            RX_CHOPPY: m_axis_tready <= 1'($urandom_range(0, 1));
            default:   m_axis_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_digests.size() == 0)
            begin
                $display("%0t: digest word with none expected: %h", $time, m_axis_tdata);
                errors++;
            end
            else
            begin
                front_dg = pending_digests.pop_front();
                digests_seen++;
                if (m_axis_tdata[63:0] !== front_dg.head)
                begin
                    $display("%0t: digest_head expected %h, got %h",
                             $time, front_dg.head, m_axis_tdata[63:0]);
                    errors++;
                end
                if (m_axis_tdata[127:64] !== front_dg.tail)
                begin
                    $display("%0t: digest_tail expected %h, got %h",
                             $time, front_dg.tail, m_axis_tdata[127:64]);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        cycle_count  = 0;
        digests_seen = 0;
        rx_left      = 0;
        rx_mode      = RX_OPEN;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("Run stopped after %0d cycles, %0d digests outstanding",
                     cycle_count, pending_digests.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

endmodule
